[src/vlra_pkg.sv]
// ----------------------------------------------------------------------------
// vlra_pkg
// Shared types and constants for the variable-length ring allocator.
// ----------------------------------------------------------------------------
package vlra_pkg;

   localparam int LEN_W = 11;
   localparam int OFF_W = 10;

   typedef enum logic {
      FUNC_ALLOC   = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_CORRUPT = 2'd3
   } status_type;

   typedef struct packed {
      status_type             status;
      logic [OFF_W-1:0]       offset;
      logic [LEN_W-1:0]       length;
   } rsp_type;

endpackage

[src/variable_length_ring_allocator_top.sv]
// ----------------------------------------------------------------------------
// variable_length_ring_allocator_top
// Ring allocator for variable-length records with a result register stage.
//
//   channel  ports                                   dir   note
//   req      req_valid, req_func, req_length_blocks  in    req_stall out
//   rsp      rsp_valid, rsp_status, rsp_offset,      out   rsp_stall in
//            rsp_length
//
// Each item is accepted in IDLE, where a release reads the head length from
// the length store RAM; EVAL then evaluates and commits pointers and result.
// A result waiting in the output register does not block acceptance; only
// the commit waits for the register to free up.
// Synchronous reset clears pointers; the length store is not cleared.
// ----------------------------------------------------------------------------
module variable_length_ring_allocator_top
   import vlra_pkg::*;
#(
   parameter int RING_BLOCKS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_func,
   input  logic [LEN_W-1:0] req_length_blocks,
   output logic             req_stall,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [OFF_W-1:0] rsp_offset,
   output logic [LEN_W-1:0] rsp_length,
   input  logic             rsp_stall
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type res;
   logic    res_load;
   logic    slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   vlra_ctrl #(
      .RING_BLOCKS(RING_BLOCKS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_func         (req_func),
      .req_length_blocks(req_length_blocks),
      .req_stall        (req_stall),
      .slot_free        (slot_free),
      .res_load         (res_load),
      .res              (res)
   );

   assign rsp_valid_in = res_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_offset = rsp_ff.offset;
   assign rsp_length = rsp_ff.length;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_load |-> slot_free)
      else $error("pending result overwritten");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      res_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      res_load |-> req_stall)
      else $error("item accepted during commit");

endmodule

[src/vlra_ram.sv]
// ----------------------------------------------------------------------------
// vlra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vlra_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/vlra_ctrl.sv]
// ----------------------------------------------------------------------------
// vlra_ctrl
// Pointer sequencer: holds read/write pointers and wrap mark, reads the head
// length from the length store and commits one item before accepting the next.
// ----------------------------------------------------------------------------
module vlra_ctrl
   import vlra_pkg::*;
#(
   parameter int RING_BLOCKS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_func,
   input  logic [LEN_W-1:0] req_length_blocks,
   output logic             req_stall,
   input  logic             slot_free,
   output logic             res_load,
   output rsp_type          res
);

   localparam int P  = $clog2(RING_BLOCKS + 1);
   localparam int AW = $clog2(RING_BLOCKS);
   localparam int CW = ((P > LEN_W) ? P : LEN_W) + 2;
   localparam logic [CW-1:0] RB_X = CW'(RING_BLOCKS);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EVAL = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [P-1:0]     rp_ff, rp_in;
   logic [P-1:0]     wp_ff, wp_in;
   logic [P-1:0]     wm_ff, wm_in;
   func_type         func_ff;
   logic [LEN_W-1:0] len_ff;

   logic             accept;
   logic             jump;
   logic [P-1:0]     head_now;
   logic [CW-1:0]    rp_x, wp_x, wm_x, head_x, len_x, rd_x, queued_x;
   logic             wrapped;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [LEN_W-1:0] rd_data;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   // pointers are stable between accept and commit, so the head computed
   // here addresses the same entry that EVAL uses
   assign jump     = (rp_ff == wm_ff);
   assign head_now = jump ? '0 : rp_ff;

   // write happens at commit, a later read is issued at the next accept:
   // no read/write overlap on one entry
   vlra_ram #(
      .WIDTH(LEN_W),
      .DEPTH(RING_BLOCKS)
   ) u_len_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(len_ff),
      .rd_en  (accept && (func_type'(req_func) == FUNC_RELEASE)),
      .rd_addr(head_now[AW-1:0]),
      .rd_data(rd_data)
   );

   assign rp_x    = CW'(rp_ff);
   assign wp_x    = CW'(wp_ff);
   assign wm_x    = CW'(wm_ff);
   assign head_x  = CW'(head_now);
   assign len_x   = CW'(len_ff);
   assign rd_x    = CW'(rd_data);
   assign wrapped = (wp_ff < rp_ff);
   assign queued_x = (rp_x < wp_x) ? (wp_x - rp_x)
                   : (((wm_x >= rp_x) ? (wm_x - rp_x) : '0) + wp_x);

   always_comb begin
      state_in = state_ff;
      rp_in    = rp_ff;
      wp_in    = wp_ff;
      wm_in    = wm_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      res_load = 1'b0;
      res      = '{status: ST_OK, offset: '0, length: '0};

      if (func_ff == FUNC_ALLOC) begin
         res.length = len_ff;
         if (len_x == '0 || len_x > RB_X) begin
            res.status = ST_NO_ROOM;
         end else if (wp_x + len_x > RB_X) begin
            if (wrapped || len_x >= rp_x) begin
               res.status = ST_NO_ROOM;
            end else begin
               wm_in   = wp_ff;
               wp_in   = P'(len_x);
               wr_en   = 1'b1;
               wr_addr = '0;
            end
         end else if (wrapped && (wp_x + len_x >= rp_x)) begin
            res.status = ST_NO_ROOM;
         end else if (wp_x >= RB_X) begin
            res.status = ST_NO_ROOM;
         end else begin
            wp_in      = P'(wp_x + len_x);
            wr_en      = 1'b1;
            wr_addr    = wp_ff[AW-1:0];
            res.offset = wp_x[OFF_W-1:0];
         end
      end else begin
         if (rp_ff == wp_ff) begin
            res.status = ST_EMPTY;
         end else if (head_x >= RB_X || rd_x == '0 || (head_x + rd_x > wm_x) ||
                      rd_x > queued_x) begin
            res.status = ST_CORRUPT;
            res.offset = head_x[OFF_W-1:0];
         end else begin
            res.offset = head_x[OFF_W-1:0];
            res.length = rd_data;
            rp_in      = P'(head_x + rd_x);
            if (jump) begin
               wm_in = P'(RB_X);
            end
         end
      end

      case (state_ff)
         S_IDLE: begin
            wr_en = 1'b0;
            rp_in = rp_ff;
            wp_in = wp_ff;
            wm_in = wm_ff;
            if (accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (slot_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               wr_en = 1'b0;
               rp_in = rp_ff;
               wp_in = wp_ff;
               wm_in = wm_ff;
            end
         end
         default: begin
            wr_en    = 1'b0;
            rp_in    = rp_ff;
            wp_in    = wp_ff;
            wm_in    = wm_ff;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rp_ff    <= '0;
         wp_ff    <= '0;
         wm_ff    <= P'(RB_X);
      end else begin
         state_ff <= state_in;
         rp_ff    <= rp_in;
         wp_ff    <= wp_in;
         wm_ff    <= wm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= func_type'(req_func);
         len_ff  <= req_length_blocks;
      end
   end

   a_load_in_eval: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (state_ff == S_EVAL))
      else $error("result committed outside EVAL");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_EVAL))
      else $error("accepted item did not reach EVAL");

   a_wp_below_mark: assert property (@(posedge clock) disable iff (reset)
      (wp_ff <= wm_ff) && (wm_ff <= P'(RB_X)))
      else $error("write pointer beyond wrap mark");

   a_ptrs_hold_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> ($stable(rp_ff) && $stable(wp_ff) && $stable(wm_ff)))
      else $error("pointers moved without a commit");

endmodule
